### hw/rtl/kfr_pkg.sv
// Shared types and codes for the keyed FIFO with removal.
// No dependencies; used by kfr_ctrl, kfr_dp and the top level.
`default_nettype none

package kfr_pkg;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_FIND_T = 3'd2;
  localparam logic [2:0] OP_FIND_G = 3'd3;
  localparam logic [2:0] OP_LIST   = 3'd4;

  localparam int KEY_W   = 16;
  localparam int TDATA_W = 40;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_ENTRY    = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic    load;
    logic    ptr_clr;
    logic    ptr_inc;
    logic    wr_app;
    logic    wr_shift;
    logic    fill_inc;
    logic    fill_dec;
    logic    hold_set;
    logic    hold_clr;
    logic    out_load;
    logic    out_from_hold;
    logic    out_last;
    status_t out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       hit;
    logic       at_end;
    logic       empty;
    logic       full;
    logic       hold_vld;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/kfr_ctrl.sv
// Command sequencer for the keyed FIFO: decodes each beat and steps the datapath.
// Depends on kfr_pkg.
`default_nettype none

module kfr_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire kfr_pkg::dp_stat_t stat_i,
  output kfr_pkg::dp_cmd_t  cmd_o
);
  import kfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_SHIFT,
    S_WALK,
    S_RESP
  } state_t;

  state_t  state_r, state_nxt;
  status_t resp_st_r, resp_st_nxt;

  always_comb begin
    cmd_o       = '0;
    state_nxt   = state_r;
    resp_st_nxt = resp_st_r;
    in_tready   = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.op)
          OP_APPEND: begin
            state_nxt = S_RESP;
            if (stat_i.full) begin
              resp_st_nxt = ST_FULL;
            end else begin
              cmd_o.wr_app   = 1'b1;
              cmd_o.fill_inc = 1'b1;
              resp_st_nxt    = ST_DONE;
            end
          end
          OP_REMOVE: begin
            if (stat_i.empty) begin
              resp_st_nxt = ST_EMPTY;
              state_nxt   = S_RESP;
            end else begin
              state_nxt = S_SEARCH;
            end
          end
          OP_FIND_T, OP_FIND_G, OP_LIST: state_nxt = S_WALK;
          default:                       state_nxt = S_IDLE;
        endcase
      end
      S_SEARCH: begin
        if (stat_i.at_end) begin
          resp_st_nxt   = ST_NOTFOUND;
          cmd_o.ptr_clr = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          if (stat_i.hit) state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat_i.at_end) begin
          cmd_o.fill_dec = 1'b1;
          cmd_o.ptr_clr  = 1'b1;
          resp_st_nxt    = ST_DONE;
          state_nxt      = S_RESP;
        end else begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.ptr_inc  = 1'b1;
        end
      end
      S_WALK: begin
        if (!stat_i.at_end) begin
          if (!stat_i.hit) begin
            cmd_o.ptr_inc = 1'b1;
          end else if (!stat_i.hold_vld) begin
            cmd_o.hold_set = 1'b1;
            cmd_o.ptr_inc  = 1'b1;
          end else if (stat_i.out_free) begin
            cmd_o.out_load      = 1'b1;
            cmd_o.out_from_hold = 1'b1;
            cmd_o.out_status    = ST_ENTRY;
            cmd_o.hold_set      = 1'b1;
            cmd_o.ptr_inc       = 1'b1;
          end
        end else if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.ptr_clr  = 1'b1;
          state_nxt      = S_IDLE;
          if (stat_i.hold_vld) begin
            cmd_o.out_from_hold = 1'b1;
            cmd_o.out_status    = ST_ENTRY;
            cmd_o.hold_clr      = 1'b1;
          end else begin
            cmd_o.out_status = stat_i.empty ? ST_EMPTY : ST_NOTFOUND;
          end
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.out_status = resp_st_r;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      resp_st_r <= ST_DONE;
    end else begin
      state_r   <= state_nxt;
      resp_st_r <= resp_st_nxt;
    end
  end

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !stat_i.hold_vld)
    else $error("held entry left over after walk");

endmodule

`default_nettype wire

### hw/rtl/kfr_dp.sv
// Datapath: slot memories, fill count, walk pointer, hold stage and output register.
// Depends on kfr_pkg; driven by kfr_ctrl.
`default_nettype none

module kfr_dp #(
  parameter int DEPTH = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire kfr_pkg::dp_cmd_t        cmd_i,
  output kfr_pkg::dp_stat_t            stat_o,
  input  wire [kfr_pkg::TDATA_W-1:0]   in_tdata,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [kfr_pkg::TDATA_W-1:0]  out_tdata,
  output logic                         out_tlast
);
  import kfr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [KEY_W-1:0] tk_mem [DEPTH];
  logic [KEY_W-1:0] gk_mem [DEPTH];

  logic [2:0]       op_r;
  logic [KEY_W-1:0] tk_r, gk_r;
  logic [KEY_W-1:0] rd_t_r, rd_g_r;
  logic [KEY_W-1:0] hold_t_r, hold_g_r;
  logic             hold_vld_r;
  logic [CW-1:0]    fill_r, ptr_r, ptr_nxt, ptr_m1;
  logic             out_vld_r, out_last_r;
  status_t          out_st_r;
  logic [KEY_W-1:0] out_t_r, out_g_r;
  logic             hit;

  assign ptr_nxt = cmd_i.ptr_clr ? '0 : (cmd_i.ptr_inc ? ptr_r + 1'b1 : ptr_r);
  assign ptr_m1  = ptr_r - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r <= in_tdata[2:0];
      tk_r <= in_tdata[KEY_W+2:3];
      gk_r <= in_tdata[2*KEY_W+2:KEY_W+3];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.wr_app) begin
      tk_mem[fill_r[AW-1:0]] <= tk_r;
      gk_mem[fill_r[AW-1:0]] <= gk_r;
    end else if (cmd_i.wr_shift) begin
      tk_mem[ptr_m1[AW-1:0]] <= rd_t_r;
      gk_mem[ptr_m1[AW-1:0]] <= rd_g_r;
    end
    rd_t_r <= tk_mem[ptr_nxt[AW-1:0]];
    rd_g_r <= gk_mem[ptr_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      ptr_r      <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      if (cmd_i.fill_inc) fill_r <= fill_r + 1'b1;
      else if (cmd_i.fill_dec) fill_r <= fill_r - 1'b1;
      if (cmd_i.hold_set) hold_vld_r <= 1'b1;
      else if (cmd_i.hold_clr) hold_vld_r <= 1'b0;
      if (cmd_i.out_load) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.hold_set) begin
      hold_t_r <= rd_t_r;
      hold_g_r <= rd_g_r;
    end
    if (cmd_i.out_load) begin
      out_st_r   <= cmd_i.out_status;
      out_last_r <= cmd_i.out_last;
      out_t_r    <= cmd_i.out_from_hold ? hold_t_r : '0;
      out_g_r    <= cmd_i.out_from_hold ? hold_g_r : '0;
    end
  end

  always_comb begin
    unique case (op_r)
      OP_FIND_G: hit = (rd_g_r == gk_r);
      OP_LIST:   hit = 1'b1;
      default:   hit = (rd_t_r == tk_r);
    endcase
  end

  assign stat_o.op       = op_r;
  assign stat_o.hit      = hit;
  assign stat_o.at_end   = (ptr_r == fill_r);
  assign stat_o.empty    = (fill_r == '0);
  assign stat_o.full     = (fill_r == CW'(DEPTH));
  assign stat_o.hold_vld = hold_vld_r;
  assign stat_o.out_free = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(TDATA_W - 2*KEY_W - 3){1'b0}}, out_g_r, out_t_r, out_st_r};

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= fill_r)
    else $error("walk pointer past fill count");

  a_hold_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> ptr_r != '0)
    else $error("held entry without walk progress");

endmodule

`default_nettype wire

### hw/rtl/keyed_fifo_with_removal_core.sv
// Top level of the keyed FIFO with removal: stream ports, controller and datapath.
// Depends on kfr_pkg, kfr_ctrl and kfr_dp.
`default_nettype none

// Ordered queue of up to DEPTH (ticket, group) entries kept compacted in two
// slot memories, each with one write port and one registered read port. One
// command beat is taken at a time; the next can be accepted in the cycle after
// the last result of the current one is loaded into the output register, which
// may still be waiting for out_tready. Append writes at the tail; remove
// searches to the match, then shifts the tail down one slot per cycle; find and
// list walk the slot memory one entry per cycle through its registered read
// port, pausing while a held match waits for a free output register. Unused
// command codes give no result.
module keyed_fifo_with_removal_core #(
  parameter int DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // cmd[2:0], ticket_key[18:3], group_key[34:19], zero pad
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // status[2:0], entry_ticket[18:3], entry_group[34:19], pad
  output logic        out_tlast
);
  import kfr_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  kfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd)
  );

  kfr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### test/keyed_fifo_with_removal_core_tb.sv
// Self-checking testbench for keyed_fifo_with_removal_core: directed and random command
// beats against a shadow queue, with random idling on both stream sides in most phases.
// Depends on kfr_pkg and the keyed_fifo_with_removal_core RTL.
module keyed_fifo_with_removal_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kfr_pkg::*;

  localparam int DEPTH      = 16;
  localparam int WDOG_LIMIT = 2000;
  localparam int END_WAIT   = 64;

  typedef struct {
    status_t     status;
    logic [15:0] ticket;
    logic [15:0] group;
    logic        last;
  } result_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;  // cmd[2:0], ticket_key[18:3], group_key[34:19], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [39:0] out_tdata;        // status[2:0], entry_ticket[18:3], entry_group[34:19], pad
  logic        out_tlast;

  logic [15:0] sh_ticket [DEPTH];
  logic [15:0] sh_group  [DEPTH];
  int          sh_fill;
  result_t     pending_results [$];

  bit in_held;
  bit in_idle_on;
  bit out_idle_on;
  int err_count;
  int wdog_count;
  int n_items, n_beats, n_removed, n_full, n_miss;

  keyed_fifo_with_removal_core #(.DEPTH(DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void apply_to_shadow_queue(logic [2:0] cmd, logic [15:0] tk,
                                                logic [15:0] gk);
    result_t batch [$];
    result_t r;
    int      pos;
    bit      hit;
    r = '{ST_DONE, 16'h0000, 16'h0000, 1'b0};
    case (cmd)
      OP_APPEND: begin
        if (sh_fill >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          sh_ticket[sh_fill] = tk;
          sh_group[sh_fill]  = gk;
          sh_fill++;
        end
        batch.push_back(r);
      end
      OP_REMOVE: begin
        pos = 0;
        while (pos < sh_fill && sh_ticket[pos] != tk) pos++;
        if (sh_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (pos == sh_fill) begin
          r.status = ST_NOTFOUND;
        end else begin
          for (int i = pos; i + 1 < sh_fill; i++) begin
            sh_ticket[i] = sh_ticket[i + 1];
            sh_group[i]  = sh_group[i + 1];
          end
          sh_fill--;
          n_removed++;
        end
        batch.push_back(r);
      end
      OP_FIND_T, OP_FIND_G, OP_LIST: begin
        for (int i = 0; i < sh_fill; i++) begin
          hit = (cmd == OP_LIST) || (cmd == OP_FIND_T && sh_ticket[i] == tk) ||
                (cmd == OP_FIND_G && sh_group[i] == gk);
          if (hit) batch.push_back('{ST_ENTRY, sh_ticket[i], sh_group[i], 1'b0});
        end
        if (batch.size() == 0) begin
          r.status = (sh_fill == 0) ? ST_EMPTY : ST_NOTFOUND;
          batch.push_back(r);
        end
      end
      default: ;
    endcase
    if (batch.size() != 0) begin
      batch[batch.size() - 1].last = 1'b1;
      if (batch[0].status == ST_EMPTY || batch[0].status == ST_NOTFOUND) n_miss++;
    end
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endfunction

  function automatic logic [15:0] rand_key();
    case ($urandom_range(0, 3))
      0:       rand_key = 16'($urandom);
      1:       rand_key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: rand_key = 16'($urandom_range(1, 6));
    endcase
  endfunction

  // drop valid and wait on the clock before returning, so it is never lowered and raised in one step
  task automatic quiet_in();
    if (in_held) begin
      in_tvalid <= 1'b0;
      in_held = 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input logic [15:0] tk,
                          input logic [15:0] gk);
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      quiet_in();
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    if (!in_held) in_tvalid <= 1'b1;
    in_held = 1'b1;
    in_tdata <= {5'b0, gk, tk, cmd};
    do @(posedge clk); while (!in_tready);
    if (cmd <= OP_LIST) n_items++;
    apply_to_shadow_queue(cmd, tk, gk);
  endtask

  task automatic wait_drain();
    quiet_in();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_cmd(OP_REMOVE, 16'h0000, 16'h0000);
    send_cmd(OP_FIND_T, 16'hFFFF, 16'h0000);
    send_cmd(OP_LIST,   16'h0000, 16'hFFFF);
    send_cmd(3'd7,      16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_full_queue();
    logic [15:0] tk, gk;
    for (int i = 0; i < DEPTH; i++) begin
      tk = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
           (i % 4 == 2) ? 16'h0005 : 16'(16'h1000 + i);
      gk = (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'(16'h00A0 + (i % 3));
      send_cmd(OP_APPEND, tk, gk);
    end
    send_cmd(OP_APPEND, 16'h7777, 16'h7777);
    send_cmd(OP_LIST,   16'h0000, 16'h0000);
    send_cmd(OP_FIND_T, 16'h0005, 16'h0000);
    send_cmd(OP_FIND_G, 16'h0000, 16'h00A1);
    send_cmd(OP_FIND_G, 16'h0000, 16'h1234);
    send_cmd(OP_REMOVE, 16'h0005, 16'h0000);
    send_cmd(OP_REMOVE, 16'hBEEF, 16'h0000);
    send_cmd(3'd5,      16'h0000, 16'h0000);
    send_cmd(OP_LIST,   16'h0000, 16'h0000);
  endtask

  task automatic test_random_traffic(input int count);
    int          done_items;
    int          r, sel, idx, app_pct, rem_pct;
    bit          grow;
    logic [2:0]  cmd;
    logic [15:0] tk, gk;
    done_items = 0;
    grow = 1'b1;
    while (done_items < count) begin
      if (done_items % 40 == 39) grow = $urandom_range(0, 1);
      app_pct = grow ? 45 : 10;
      rem_pct = grow ? 15 : 50;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        cmd = 3'(5 + $urandom_range(0, 2));
      end else if (r < 4 + app_pct) begin
        cmd = OP_APPEND;
      end else if (r < 4 + app_pct + rem_pct) begin
        cmd = OP_REMOVE;
      end else begin
        sel = $urandom_range(0, 9);
        cmd = (sel < 4) ? OP_FIND_T : (sel < 8) ? OP_FIND_G : OP_LIST;
      end
      tk = rand_key();
      gk = rand_key();
      if (sh_fill != 0 && $urandom_range(0, 4) != 0) begin
        idx = $urandom_range(0, sh_fill - 1);
        if (cmd == OP_REMOVE || cmd == OP_FIND_T) tk = sh_ticket[idx];
        if (cmd == OP_FIND_G) gk = sh_group[idx];
      end
      send_cmd(cmd, tk, gk);
      if (cmd <= OP_LIST) done_items++;
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (out_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_beats++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result beat: tdata %h last %b", out_tdata, out_tlast);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[2:0] !== want.status || out_tdata[18:3] !== want.ticket ||
            out_tdata[34:19] !== want.group || out_tlast !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected status %0d ticket %h group %h last %b, got %0d %h %h %b",
                     want.status, want.ticket, want.group, want.last,
                     out_tdata[2:0], out_tdata[18:3], out_tdata[34:19], out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      wdog_count <= 0;
    end else begin
      wdog_count <= wdog_count + 1;
      if (wdog_count >= WDOG_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", WDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    sh_fill     = 0;
    in_held     = 1'b0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_full_queue();
    wait_drain();

    test_random_traffic(170);
    wait_drain();

    in_idle_on = 1'b0;
    test_random_traffic(100);

    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    test_random_traffic(75);

    wait_drain();
    repeat (END_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      err_count++;
      $display("%0d expected result beats never arrived", pending_results.size());
    end

    $display("ran %0d commands giving %0d result beats: %0d removals, %0d full rejects,",
             n_items, n_beats, n_removed, n_full);
    $display("%0d empty or not-found replies, with idling on both sides", n_miss);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
